// ----- src/luma_cross_dilate_erode_assert.svh -----
// Assertion macros for the luma cross dilate/erode block.
// Included by luma_cross_dilate_erode, which checks its own control logic; needs no package.
`ifndef LUMA_CROSS_DILATE_ERODE_ASSERT_SVH
`define LUMA_CROSS_DILATE_ERODE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LCDE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LCDE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/lcde_pkg.sv -----
// Shared types, constants and functions of the luma cross dilate/erode block.
// Used by lcde_pick and luma_cross_dilate_erode; depends on nothing.
`default_nettype none

package lcde_pkg;

  // Input item codes
  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_e;

  // Configuration register indexes
  typedef enum logic {
    CFG_ERODE_MODE = 1'b0,
    CFG_LINE_WIDTH = 1'b1
  } cfg_idx_e;

  localparam int unsigned CFG_DATA_W  = 12;
  localparam int unsigned LINE_W_BITS = 12;
  localparam logic [LINE_W_BITS-1:0] LINE_WIDTH_RESET = 12'd2048;

  localparam int unsigned PIXEL_W = 32;
  localparam int unsigned LUMA_W  = 16;

  localparam logic [LUMA_W-1:0] LUMA_R_COEF = 16'd90;
  localparam logic [LUMA_W-1:0] LUMA_G_COEF = 16'd115;
  localparam logic [LUMA_W-1:0] LUMA_B_COEF = 16'd51;

  typedef struct packed {
    op_e                op;
    logic [PIXEL_W-1:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel_out;
    logic               frame_last;
  } out_item_t;

  // One candidate pixel with its brightness
  typedef struct packed {
    logic [PIXEL_W-1:0] word;
    logic [LUMA_W-1:0]  luma;
  } cand_t;

  // Full neighbourhood of one output pixel, in test order
  typedef struct packed {
    cand_t center;
    cand_t down;
    cand_t right;
    cand_t up;
    cand_t left;
    logic  frame_last;
  } cand_set_t;

  // Brightness 90R + 115G + 51B; the maximum 65280 fits in 16 bits
  function automatic logic [LUMA_W-1:0] luma_of(input logic [PIXEL_W-1:0] p);
    logic [LUMA_W-1:0] r;
    logic [LUMA_W-1:0] g;
    logic [LUMA_W-1:0] b;
    r = LUMA_W'(p[23:16]);
    g = LUMA_W'(p[15:8]);
    b = LUMA_W'(p[7:0]);
    return LUMA_W'(r * LUMA_R_COEF + g * LUMA_G_COEF + b * LUMA_B_COEF);
  endfunction

  // A candidate wins only when strictly better than the current choice
  function automatic logic better(input logic [LUMA_W-1:0] cand,
                                  input logic [LUMA_W-1:0] cur,
                                  input logic              erode);
    return erode ? (cand < cur) : (cand > cur);
  endfunction

endpackage

`default_nettype wire

// ----- src/lcde_ram.sv -----
// Generic synchronous RAM: one write port, two read ports, registered read data.
// Read data shows the old contents on a same-address write; depends on nothing.
`default_nettype none

module lcde_ram #(
  parameter int unsigned DATA_W = 32,
  parameter int unsigned DEPTH  = 2048
) (
  input  wire                       clk_i,
  input  wire                       we_i,
  input  wire [$clog2(DEPTH)-1:0]   waddr_i,
  input  wire [DATA_W-1:0]          wdata_i,
  input  wire                       re_i,
  input  wire [$clog2(DEPTH)-1:0]   raddr_a_i,
  input  wire [$clog2(DEPTH)-1:0]   raddr_b_i,
  output logic [DATA_W-1:0]         rdata_a_o,
  output logic [DATA_W-1:0]         rdata_b_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];

  // Write and read; reads return the contents before this edge's write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

`default_nettype wire

// ----- src/lcde_pick.sv -----
// Selection pipeline: picks the brightest or darkest of five candidates over
// two register stages, the second one being the output register. Uses lcde_pkg.
`default_nettype none

module lcde_pick (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   erode_i,
  input  wire                   valid_i,
  output logic                  stall_o,
  input  wire lcde_pkg::cand_set_t cands_i,
  output logic                  out_valid_o,
  input  wire                   out_stall_i,
  output lcde_pkg::out_item_t   out_data_o
);

  logic                out_valid_q;
  lcde_pkg::out_item_t out_q;
  logic                out_adv;

  logic                v2_q;
  logic                s2_adv;
  lcde_pkg::cand_t     best2_d;
  lcde_pkg::cand_t     best2_q;
  lcde_pkg::cand_t     up2_q;
  lcde_pkg::cand_t     left2_q;
  logic                last2_q;
  lcde_pkg::cand_t     best3_d;

  // Stage advance: a stage moves when the one after it is empty or moving
  assign out_adv = !out_valid_q || !out_stall_i;
  assign s2_adv  = !v2_q || out_adv;
  assign stall_o = !s2_adv;

  // Test center, down, right in order
  always_comb begin
    best2_d = cands_i.center;
    if (lcde_pkg::better(cands_i.down.luma, best2_d.luma, erode_i)) begin
      best2_d = cands_i.down;
    end
    if (lcde_pkg::better(cands_i.right.luma, best2_d.luma, erode_i)) begin
      best2_d = cands_i.right;
    end
  end

  // Then up and left
  always_comb begin
    best3_d = best2_q;
    if (lcde_pkg::better(up2_q.luma, best3_d.luma, erode_i)) begin
      best3_d = up2_q;
    end
    if (lcde_pkg::better(left2_q.luma, best3_d.luma, erode_i)) begin
      best3_d = left2_q;
    end
  end

  // Stage two valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (s2_adv) begin
      v2_q <= valid_i;
    end
  end

  // Stage two payload
  always_ff @(posedge clk_i) begin
    if (s2_adv && valid_i) begin
      best2_q <= best2_d;
      up2_q   <= cands_i.up;
      left2_q <= cands_i.left;
      last2_q <= cands_i.frame_last;
    end
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= v2_q;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (out_adv && v2_q) begin
      out_q.pixel_out  <= best3_d.word;
      out_q.frame_last <= last2_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ----- src/luma_cross_dilate_erode.sv -----
// Top level of the plus-shaped luma dilate/erode filter: counters, two line
// banks in lcde_ram, candidate fetch, and the lcde_pick selection pipeline.
// Uses lcde_pkg and luma_cross_dilate_erode_assert.svh.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+---------------------------
//   in      | input     | in_valid_i / in_stall_o  | in_data_i (op, pixel_in)
//   out     | output    | out_valid_o / out_stall_i| out_data_o (pixel_out, frame_last)
//   cfg     | input     | cfg_we_i                 | cfg_index_i, cfg_data_i
//
// One item per clock sustained while out_stall_i is low; a result leaves after its item
// is taken, through the line bank read, the first selection stage and the output register.
// Throughput is set by the two dual-read line banks: each item does at most one read
// of both banks and at most one write, so no item waits on another.
// Reset clears counters, valid bits, configuration and left neighbour; the line banks need no clearing pass.
// An output stall backs up through the pipeline stages to in_stall_o.
`default_nettype none
`include "luma_cross_dilate_erode_assert.svh"

module luma_cross_dilate_erode #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  wire lcde_pkg::in_item_t          in_data_i,
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output lcde_pkg::out_item_t              out_data_o,
  input  wire                              cfg_we_i,
  input  wire                              cfg_index_i,
  input  wire [lcde_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);

  // Configuration
  logic                               erode_q;
  logic [lcde_pkg::LINE_W_BITS-1:0]   line_width_q;
  logic [31:0]                        lw_ext;
  logic [WW-1:0]                      w_eff;

  // Frame counters
  logic [AW-1:0]  col_q;
  logic [AW-1:0]  col_d;
  logic [AW-1:0]  drain_q;
  logic [AW-1:0]  drain_d;
  logic [1:0]     rows_q;
  logic [1:0]     rows_d;

  // Item decode
  logic           is_drain;
  logic [AW-1:0]  c_col;
  logic [AW-1:0]  d_col;
  logic [AW-1:0]  c_item;
  logic [WW-1:0]  c_next;
  logic [WW-1:0]  c_col_next;
  logic [WW-1:0]  d_col_next;
  logic           produce;
  logic           wr_en;
  logic           item_last;
  logic           in_fire;
  logic           load1;

  // Pipeline control
  logic           v1_q;
  logic           adv1;
  logic           adv2;
  logic           pick_stall;

  // Stage one payload
  logic                            s1_bank_q;
  logic                            s1_has_up_q;
  logic                            s1_right_ok_q;
  logic                            s1_left_ok_q;
  logic                            s1_drain_q;
  logic                            s1_last_q;
  logic [lcde_pkg::PIXEL_W-1:0]    s1_down_q;
  logic [lcde_pkg::LUMA_W-1:0]     s1_down_luma_q;

  // Left neighbour: center of the previous result
  lcde_pkg::cand_t                 left_q;

  // Line banks
  logic [lcde_pkg::PIXEL_W-1:0]    b0_rd_a;
  logic [lcde_pkg::PIXEL_W-1:0]    b0_rd_b;
  logic [lcde_pkg::PIXEL_W-1:0]    b1_rd_a;
  logic [lcde_pkg::PIXEL_W-1:0]    b1_rd_b;
  logic [AW-1:0]                   raddr_b;

  // Candidates
  logic [lcde_pkg::PIXEL_W-1:0]    center_raw;
  logic [lcde_pkg::PIXEL_W-1:0]    right_raw;
  logic [lcde_pkg::PIXEL_W-1:0]    up_raw;
  lcde_pkg::cand_t                 center_c;
  lcde_pkg::cand_t                 right_c;
  lcde_pkg::cand_t                 up_c;
  lcde_pkg::cand_set_t             cands;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      erode_q      <= 1'b0;
      line_width_q <= lcde_pkg::LINE_WIDTH_RESET;
    end else if (cfg_we_i) begin
      if (cfg_index_i == lcde_pkg::CFG_ERODE_MODE) begin
        erode_q <= cfg_data_i[0];
      end else if (cfg_index_i == lcde_pkg::CFG_LINE_WIDTH) begin
        line_width_q <= cfg_data_i;
      end
    end
  end

  // Clamp the width to one through MAX_WIDTH
  always_comb begin
    lw_ext = 32'(line_width_q);
    if (lw_ext == 32'd0) begin
      w_eff = WW'(1);
    end else if (lw_ext > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(lw_ext);
    end
  end

  // Decode the incoming item and work out the next counter values
  always_comb begin
    is_drain   = (in_data_i.op == lcde_pkg::OP_DRAIN);
    c_col      = (WW'(col_q) >= w_eff) ? '0 : col_q;
    d_col      = (WW'(drain_q) >= w_eff) ? '0 : drain_q;
    c_col_next = WW'(c_col) + WW'(1);
    d_col_next = WW'(d_col) + WW'(1);
    c_item     = is_drain ? d_col : c_col;
    c_next     = is_drain ? d_col_next : c_col_next;
    wr_en      = !is_drain && (d_col == '0);
    produce    = (rows_q != 2'd0) && (is_drain || (d_col == '0));
    item_last  = is_drain && (c_next >= w_eff);

    col_d   = c_col;
    drain_d = d_col;
    rows_d  = rows_q;
    if (!is_drain) begin
      if (d_col == '0) begin
        if (c_col_next >= w_eff) begin
          col_d  = '0;
          rows_d = (rows_q == 2'd3) ? 2'd2 : rows_q + 2'd1;
        end else begin
          col_d = AW'(c_col_next);
        end
      end
    end else if (rows_q != 2'd0) begin
      col_d = '0;
      if (item_last) begin
        drain_d = '0;
        rows_d  = 2'd0;
      end else begin
        drain_d = AW'(d_col_next);
      end
    end
  end

  // Handshake: take an item when stage one is free or moving on
  assign adv2       = !pick_stall;
  assign adv1       = !v1_q || adv2;
  assign in_stall_o = !adv1;
  assign in_fire    = in_valid_i && adv1;
  assign load1      = in_fire && produce;

  // Advance the frame counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      drain_q <= '0;
      rows_q  <= 2'd0;
    end else if (in_fire) begin
      col_q   <= col_d;
      drain_q <= drain_d;
      rows_q  <= rows_d;
    end
  end

  // Line banks; bank rows_q[0] takes the row that is arriving
  assign raddr_b = AW'(c_next);

  lcde_ram #(
    .DATA_W (lcde_pkg::PIXEL_W),
    .DEPTH  (MAX_WIDTH)
  ) u_bank0 (
    .clk_i     (clk_i),
    .we_i      (in_fire && wr_en && !rows_q[0]),
    .waddr_i   (c_col),
    .wdata_i   (in_data_i.pixel_in),
    .re_i      (load1),
    .raddr_a_i (c_item),
    .raddr_b_i (raddr_b),
    .rdata_a_o (b0_rd_a),
    .rdata_b_o (b0_rd_b)
  );

  lcde_ram #(
    .DATA_W (lcde_pkg::PIXEL_W),
    .DEPTH  (MAX_WIDTH)
  ) u_bank1 (
    .clk_i     (clk_i),
    .we_i      (in_fire && wr_en && rows_q[0]),
    .waddr_i   (c_col),
    .wdata_i   (in_data_i.pixel_in),
    .re_i      (load1),
    .raddr_a_i (c_item),
    .raddr_b_i (raddr_b),
    .rdata_a_o (b1_rd_a),
    .rdata_b_o (b1_rd_b)
  );

  // Stage one valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (load1) begin
      v1_q <= 1'b1;
    end else if (adv2) begin
      v1_q <= 1'b0;
    end
  end

  // Stage one payload, captured alongside the bank read
  always_ff @(posedge clk_i) begin
    if (load1) begin
      s1_bank_q      <= ~rows_q[0];
      s1_has_up_q    <= rows_q[1];
      s1_right_ok_q  <= (c_next < w_eff);
      s1_left_ok_q   <= (c_item != '0);
      s1_drain_q     <= is_drain;
      s1_last_q      <= item_last;
      s1_down_q      <= in_data_i.pixel_in;
      s1_down_luma_q <= lcde_pkg::luma_of(in_data_i.pixel_in);
    end
  end

  // Pick center, right and up from the banks; clamp at the frame edges
  always_comb begin
    center_raw = s1_bank_q ? b1_rd_a : b0_rd_a;
    right_raw  = s1_bank_q ? b1_rd_b : b0_rd_b;
    up_raw     = s1_bank_q ? b0_rd_a : b1_rd_a;

    center_c.word = center_raw;
    center_c.luma = lcde_pkg::luma_of(center_raw);
    right_c.word  = right_raw;
    right_c.luma  = lcde_pkg::luma_of(right_raw);
    up_c.word     = up_raw;
    up_c.luma     = lcde_pkg::luma_of(up_raw);

    cands.center     = center_c;
    cands.right      = s1_right_ok_q ? right_c : center_c;
    cands.up         = s1_has_up_q ? up_c : center_c;
    cands.left       = s1_left_ok_q ? left_q : center_c;
    cands.frame_last = s1_last_q;
    if (s1_drain_q) begin
      cands.down = center_c;
    end else begin
      cands.down.word = s1_down_q;
      cands.down.luma = s1_down_luma_q;
    end
  end

  // Hold the center of each result as the next one's left neighbour
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
    end else if (v1_q && adv2) begin
      left_q <= center_c;
    end
  end

  lcde_pick u_pick (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .erode_i     (erode_q),
    .valid_i     (v1_q),
    .stall_o     (pick_stall),
    .cands_i     (cands),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // A drain in progress always has a complete row behind it
  `LCDE_ASSERT_IMP(a_drain_has_row, clk_i, rst_ni, drain_q != '0, rows_q != 2'd0, "drain without row")

  // Bank 0 port A and bank 1 port B read data must hold while stage one is stalled
  `LCDE_ASSERT_NXT(a_bank_hold, clk_i, rst_ni, v1_q && !adv2, $stable(b0_rd_a) && $stable(b1_rd_b) && v1_q, "bank data lost on stall")

  // Stage one empties when it moves on with nothing new behind it
  `LCDE_ASSERT_NXT(a_stage1_empty, clk_i, rst_ni, adv1 && !load1, !v1_q, "stale stage one item")

  // Only a drain can close the frame
  `LCDE_ASSERT_IMP(a_last_from_drain, clk_i, rst_ni, v1_q && s1_last_q, s1_drain_q, "frame end not from drain")

endmodule

`default_nettype wire
